FILE: hdl/txtcon_pkg.sv
// Shared types and constants for the text console writer.
// Field widths, command codes, character constants and the
// controller/datapath command and status structs. No dependencies.
package txtcon_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int CADDR_W    = 11;
    localparam int OROW_W     = 5;
    localparam int OCOL_W     = 7;
    localparam int OPOS_W     = 11;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

    // register index taken from paddr above the byte offset
    localparam logic [CFG_ADDR_W-3:0] REG_TEXT_COLOR = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_BACK  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic accept;      // input transfer this cycle, execute command
        logic fill;        // write one blank cell at the sweep counter
        logic fill_reset;  // blank uses the reset attribute
        logic scroll;      // one copy step of the scroll sweep
        logic finish;      // load result into the output stage
    } t_ctrl;

    typedef struct packed {
        logic will_scroll;
        logic cnt_last;
        logic out_free;
    } t_stat;

endpackage

FILE: hdl/txtcon_ctrl.sv
// Sequencer for the text console writer: init sweep, command dispatch,
// fill and scroll sweeps, result hand-off. Depends on txtcon_pkg.
module txtcon_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [txtcon_pkg::CMD_W-1:0]  i_command,
    input  txtcon_pkg::t_stat             i_stat,
    output logic                          o_in_ready,
    output txtcon_pkg::t_ctrl             o_ctrl
);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_FILL   = 5'b00100,
        ST_SCROLL = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    txtcon_pkg::t_cmd    cmd;

    assign cmd = txtcon_pkg::t_cmd'(i_command);

    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_ctrl.fill       = 1'b1;
                o_ctrl.fill_reset = 1'b1;
                if (i_stat.cnt_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_ctrl.accept = i_in_valid;
                if (i_in_valid) begin
                    unique case (cmd)
                        txtcon_pkg::CMD_PUT:
                            n_state = i_stat.will_scroll ? ST_SCROLL : ST_FINISH;
                        txtcon_pkg::CMD_CLEAR: n_state = ST_FILL;
                        default:               n_state = ST_FINISH;
                    endcase
                end
            end
            ST_FILL: begin
                o_ctrl.fill = 1'b1;
                if (i_stat.cnt_last) n_state = ST_FINISH;
            end
            ST_SCROLL: begin
                o_ctrl.scroll = 1'b1;
                if (i_stat.cnt_last) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                o_ctrl.finish = 1'b1;
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/txtcon_dp.sv
// Datapath of the text console writer: cell memory, cursor registers,
// sweep counter and output stage. Depends on txtcon_pkg.
module txtcon_dp #(
    parameter int COLUMNS = txtcon_pkg::DEF_COLUMNS,
    parameter int ROWS    = txtcon_pkg::DEF_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  txtcon_pkg::t_ctrl                i_ctrl,
    output txtcon_pkg::t_stat                o_stat,
    input  logic [txtcon_pkg::CMD_W-1:0]     i_command,
    input  logic [txtcon_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [txtcon_pkg::CADDR_W-1:0]   i_cell_address,
    input  logic [txtcon_pkg::COLOR_W-1:0]   i_text_color,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [txtcon_pkg::OROW_W-1:0]    o_cursor_row,
    output logic [txtcon_pkg::OCOL_W-1:0]    o_cursor_col,
    output logic [txtcon_pkg::OPOS_W-1:0]    o_cursor_position,
    output logic                             o_scrolled,
    output logic [txtcon_pkg::CELL_W-1:0]    o_read_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;
    localparam int COPY_END   = CELL_COUNT - COLUMNS;

    logic [txtcon_pkg::CELL_W-1:0] r_cells [CELL_COUNT];
    logic [txtcon_pkg::CELL_W-1:0] r_q;

    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic              r_scrolled, r_rd_hit;
    logic              r_out_valid;

    txtcon_pkg::t_cmd  cmd;
    logic              is_nl, at_row_end, at_last_row, will_scroll, addr_hit;
    logic [ADDR_W:0]   copy_src;
    logic              src_ok, copy_live, out_free;
    logic              we, re;
    logic [ADDR_W-1:0] wa, ra;
    logic [txtcon_pkg::CELL_W-1:0] wd;
    logic [txtcon_pkg::CELL_W-1:0] blank;

    assign cmd         = txtcon_pkg::t_cmd'(i_command);
    assign is_nl       = (i_char_code == txtcon_pkg::NEWLINE_CHAR);
    assign at_row_end  = (r_col == COL_W'(COLUMNS - 1));
    assign at_last_row = (r_row == ROW_W'(ROWS - 1));
    assign will_scroll = (cmd == txtcon_pkg::CMD_PUT) && (is_nl || at_row_end) && at_last_row;
    assign addr_hit    = (32'(i_cell_address) < 32'(CELL_COUNT));
    assign blank       = {i_text_color, txtcon_pkg::BLANK_CHAR};

    // scroll pipeline: source read in the cycle before the destination write
    assign copy_src  = {1'b0, r_cnt} + (ADDR_W+1)'(COLUMNS + 1);
    assign src_ok    = (copy_src < (ADDR_W+1)'(CELL_COUNT));
    assign copy_live = (r_cnt < ADDR_W'(COPY_END));
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_stat.will_scroll = will_scroll;
    assign o_stat.cnt_last    = (r_cnt == ADDR_W'(CELL_COUNT - 1));
    assign o_stat.out_free    = out_free;

    // cursor update
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_pos = r_pos;
        if (i_ctrl.accept) begin
            unique case (cmd)
                txtcon_pkg::CMD_PUT: begin
                    if (will_scroll) begin
                        n_row = ROW_W'(ROWS - 1);
                        n_col = '0;
                        n_pos = ADDR_W'(LAST_BASE);
                    end else if (is_nl || at_row_end) begin
                        n_row = r_row + 1'b1;
                        n_col = '0;
                        n_pos = is_nl ? (r_pos - ADDR_W'(r_col) + ADDR_W'(COLUMNS))
                                      : (r_pos + 1'b1);
                    end else begin
                        n_col = r_col + 1'b1;
                        n_pos = r_pos + 1'b1;
                    end
                end
                txtcon_pkg::CMD_CLEAR: begin
                    n_row = '0;
                    n_col = '0;
                    n_pos = '0;
                end
                txtcon_pkg::CMD_BACK: begin
                    if (r_col != '0) begin
                        n_col = r_col - 1'b1;
                        n_pos = r_pos - 1'b1;
                    end else if (r_row != '0) begin
                        n_row = r_row - 1'b1;
                        n_col = COL_W'(COLUMNS - 1);
                        n_pos = r_pos - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (i_ctrl.accept) begin
            n_cnt = '0;
        end else if (i_ctrl.fill || i_ctrl.scroll) begin
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    // memory port selection
    always_comb begin
        we = 1'b0;
        wa = r_cnt;
        wd = blank;
        priority if (i_ctrl.accept && cmd == txtcon_pkg::CMD_PUT && !is_nl) begin
            we = 1'b1;
            wa = r_pos;
            wd = {i_text_color, i_char_code};
        end else if (i_ctrl.fill) begin
            we = 1'b1;
            wd = {(i_ctrl.fill_reset ? txtcon_pkg::RESET_COLOR : i_text_color),
                  txtcon_pkg::BLANK_CHAR};
        end else if (i_ctrl.scroll) begin
            we = 1'b1;
            wd = copy_live ? r_q : blank;
        end else begin
        end
    end

    always_comb begin
        re = 1'b0;
        ra = ADDR_W'(i_cell_address);
        priority if (i_ctrl.accept && cmd == txtcon_pkg::CMD_READ && addr_hit) begin
            re = 1'b1;
        end else if (i_ctrl.accept && will_scroll) begin
            re = 1'b1;
            ra = ADDR_W'(COLUMNS);
        end else if (i_ctrl.scroll && src_ok) begin
            re = 1'b1;
            ra = copy_src[ADDR_W-1:0];
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_cells[wa] <= wd;
        end
        if (re) begin
            r_q <= r_cells[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_pos <= n_pos;
            r_cnt <= n_cnt;
            if (i_ctrl.finish && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_scrolled <= will_scroll;
            r_rd_hit   <= (cmd == txtcon_pkg::CMD_READ) && addr_hit;
        end
        if (i_ctrl.finish && out_free) begin
            o_cursor_row      <= txtcon_pkg::OROW_W'(r_row);
            o_cursor_col      <= txtcon_pkg::OCOL_W'(r_col);
            o_cursor_position <= txtcon_pkg::OPOS_W'(r_pos);
            o_scrolled        <= r_scrolled;
            o_read_data       <= r_rd_hit ? r_q : '0;
        end
    end

    assign o_out_valid = r_out_valid;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(COLUMNS - 1))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_W'(ROWS - 1))
        else $error("cursor row out of range");

    a_pos_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_pos) == int'(r_row) * COLUMNS + int'(r_col))
        else $error("linear cursor position lost track of row and column");

    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_scrolled) |->
            (o_cursor_col == '0 &&
             o_cursor_position == txtcon_pkg::OPOS_W'(LAST_BASE)))
        else $error("scrolled result not at start of bottom row");

endmodule

FILE: hdl/text_console_writer_core.sv
// Text console writer, top level: APB register, sequencer and datapath.
// Depends on txtcon_pkg, txtcon_ctrl, txtcon_dp.
//
// Usage: each command is one transfer on the input channel (i_in_valid /
// o_in_ready); each produces exactly one result on the output channel
// (o_out_valid / i_out_ready) with the cursor after the command, a scroll
// flag and, for reads, the cell contents.
// Put, cursor back and read go from the transfer cycle straight to the
// result load cycle; o_out_valid rises once the result is loaded.
// Put that scrolls first sweeps all ROWS*COLUMNS cells (one cell copied per
// cycle through the memory ports); clear first sweeps them too (one cell
// blanked per cycle). One command is in flight at a time.
// After reset the cell memory is swept to spaces in attribute 7, while
// o_in_ready stays low; register writes are taken during the sweep.
// The output stage holds one result: a new command is accepted while a
// result waits, but the next result is held back until the stage frees.
// text_color is at byte address 0; write it only while no command is open.
module text_console_writer_core #(
    parameter int COLUMNS = txtcon_pkg::DEF_COLUMNS,
    parameter int ROWS    = txtcon_pkg::DEF_ROWS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [txtcon_pkg::CMD_W-1:0]        i_command,
    input  logic [txtcon_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [txtcon_pkg::CADDR_W-1:0]      i_cell_address,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [txtcon_pkg::OROW_W-1:0]       o_cursor_row,
    output logic [txtcon_pkg::OCOL_W-1:0]       o_cursor_col,
    output logic [txtcon_pkg::OPOS_W-1:0]       o_cursor_position,
    output logic                                o_scrolled,
    output logic [txtcon_pkg::CELL_W-1:0]       o_read_data,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [txtcon_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [txtcon_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [txtcon_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                pready
);

    logic [txtcon_pkg::COLOR_W-1:0] r_text_color;
    logic                           reg_sel;
    txtcon_pkg::t_ctrl              ctrl;
    txtcon_pkg::t_stat              stat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[txtcon_pkg::CFG_ADDR_W-1:2] == txtcon_pkg::REG_TEXT_COLOR);
    assign prdata  = reg_sel ? txtcon_pkg::CFG_DATA_W'(r_text_color) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= txtcon_pkg::RESET_COLOR;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_text_color <= pwdata[txtcon_pkg::COLOR_W-1:0];
        end
    end

    txtcon_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_ctrl     (ctrl)
    );

    txtcon_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (ctrl),
        .o_stat            (stat),
        .i_command         (i_command),
        .i_char_code       (i_char_code),
        .i_cell_address    (i_cell_address),
        .i_text_color      (r_text_color),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_col      (o_cursor_col),
        .o_cursor_position (o_cursor_position),
        .o_scrolled        (o_scrolled),
        .o_read_data       (o_read_data)
    );

endmodule
